// ===== rtl/sorted_list_neighbor_removal_unit_macros.svh =====
// assertion macros for the sorted list neighbor removal unit
// used by the checker; no other dependencies
`ifndef SORTED_LIST_NEIGHBOR_REMOVAL_UNIT_MACROS_SVH
`define SORTED_LIST_NEIGHBOR_REMOVAL_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SLNR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("slnr check failed");

// next-cycle implication, disabled while reset is asserted
`define SLNR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("slnr check failed");

`endif

// ===== rtl/slnr_pkg.sv =====
// shared types and constants of the sorted list neighbor removal unit
// no dependencies
`default_nettype none

package slnr_pkg;

	localparam int unsigned DEPTH_DEFAULT = 16;

	localparam int unsigned FUNC_W   = 2;
	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned IDX_W    = 4;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned COUNT_W  = 5;

	// operation codes
	localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd3;

	// comparator result
	typedef struct packed {
		logic lt;
		logic eq;
	} cmp_res_t;

endpackage

`default_nettype wire

// ===== rtl/slnr_if.sv =====
// request and response channel interfaces
// depends on slnr_pkg
`default_nettype none

interface slnr_req_if;
	logic                                valid;
	logic                                ready;
	logic [slnr_pkg::FUNC_W-1:0]         func;
	logic signed [slnr_pkg::VALUE_W-1:0] value;
	logic [slnr_pkg::IDX_W-1:0]          index;

	modport source (output valid, func, value, index, input ready);
	modport sink (input valid, func, value, index, output ready);
endinterface

interface slnr_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [slnr_pkg::STATUS_W-1:0]       status;
	logic signed [slnr_pkg::VALUE_W-1:0] read_value;
	logic [slnr_pkg::COUNT_W-1:0]        entry_count;
	logic [slnr_pkg::COUNT_W-1:0]        removed_count;

	modport source (output valid, status, read_value, entry_count, removed_count, input ready);
	modport sink (input valid, status, read_value, entry_count, removed_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/slnr_ram.sv =====
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none

module slnr_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/slnr_cmp.sv =====
// shared compare unit: signed less-than and equality of a stored word against the key
// depends on slnr_pkg
`default_nettype none

module slnr_cmp (
	input  wire logic [slnr_pkg::VALUE_W-1:0] entry,
	input  wire logic [slnr_pkg::VALUE_W-1:0] key,
	output slnr_pkg::cmp_res_t                res
);
	import slnr_pkg::*;

	// two's complement ordering
	always_comb begin
		res.lt = $signed(entry) < $signed(key);
		res.eq = (entry == key);
	end

endmodule

`default_nettype wire

// ===== rtl/sorted_list_neighbor_removal_unit.sv =====
// insert: compare entries from the front until one is not below the key, then shift entries
// back from the end one by one and write the key; remove: scan every entry, and for each drop
// move the entries behind it one place forward; read: address the ram, then take the data.
// one item at a time; the ram has one write and one read port with registered read data.
// a waiting result does not block the next accept; reset empties the store, no clearing pass
// depends on slnr_pkg, slnr_if, slnr_ram, slnr_cmp
`default_nettype none

module sorted_list_neighbor_removal_unit #(
	parameter int unsigned DEPTH = slnr_pkg::DEPTH_DEFAULT
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	slnr_req_if.sink   req,
	slnr_rsp_if.source rsp
);
	import slnr_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned XW = (CW > IDX_W) ? CW : IDX_W;

	// sequencer states
	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_INS_RD  = 4'd1;
	localparam logic [3:0] S_INS_CMP = 4'd2;
	localparam logic [3:0] S_INS_SH  = 4'd3;
	localparam logic [3:0] S_INS_WR  = 4'd4;
	localparam logic [3:0] S_RD_ADDR = 4'd5;
	localparam logic [3:0] S_RD_DATA = 4'd6;
	localparam logic [3:0] S_RM_RD   = 4'd7;
	localparam logic [3:0] S_RM_CMP  = 4'd8;
	localparam logic [3:0] S_DR_SH   = 4'd9;
	localparam logic [3:0] S_DR_WR   = 4'd10;
	localparam logic [3:0] S_DONE    = 4'd11;

	logic [3:0]          state_q;
	logic [CW-1:0]       cnt_q;
	logic [CW-1:0]       ptr_q;
	logic [CW-1:0]       k_q;
	logic [CW-1:0]       removed_q;
	logic                found_q;
	logic                drop_succ_q;
	logic [FUNC_W-1:0]   func_q;
	logic [VALUE_W-1:0]  key_q;
	logic [XW-1:0]       idx_q;
	logic [STATUS_W-1:0] status_q;
	logic [VALUE_W-1:0]  rd_q;

	logic                rsp_valid_q;
	logic [STATUS_W-1:0] rsp_status_q;
	logic [VALUE_W-1:0]  rsp_value_q;
	logic [COUNT_W-1:0]  rsp_entry_q;
	logic [COUNT_W-1:0]  rsp_removed_q;

	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [VALUE_W-1:0]  ram_wdata;
	logic [AW-1:0]       ram_raddr;
	logic [VALUE_W-1:0]  ram_rdata;
	cmp_res_t            cmp;

	logic [CW-1:0]       k_dec;
	logic [CW-1:0]       k_inc;
	logic [CW-1:0]       ptr_inc;
	logic                load_rsp;

	assign k_dec    = k_q - 1'b1;
	assign k_inc    = k_q + 1'b1;
	assign ptr_inc  = ptr_q + 1'b1;
	assign load_rsp = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);

	assign req.ready         = (state_q == S_IDLE);
	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = rsp_status_q;
	assign rsp.read_value    = rsp_value_q;
	assign rsp.entry_count   = rsp_entry_q;
	assign rsp.removed_count = rsp_removed_q;

	slnr_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	slnr_cmp u_cmp (
		.entry (ram_rdata),
		.key   (key_q),
		.res   (cmp)
	);

	// ram address and write control per step
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_raddr = '0;
		case (state_q)
			S_INS_RD: begin
				ram_raddr = ptr_q[AW-1:0];
			end
			S_INS_SH: begin
				if (k_q == ptr_q) begin
					ram_we    = 1'b1;
					ram_waddr = ptr_q[AW-1:0];
					ram_wdata = key_q;
				end else begin
					ram_raddr = k_dec[AW-1:0];
				end
			end
			S_INS_WR: begin
				ram_we    = 1'b1;
				ram_waddr = k_q[AW-1:0];
				ram_wdata = ram_rdata;
			end
			S_RD_ADDR: begin
				ram_raddr = idx_q[AW-1:0];
			end
			S_RM_RD: begin
				ram_raddr = ptr_q[AW-1:0];
			end
			S_DR_SH: begin
				ram_raddr = k_inc[AW-1:0];
			end
			S_DR_WR: begin
				ram_we    = 1'b1;
				ram_waddr = k_q[AW-1:0];
				ram_wdata = ram_rdata;
			end
			default: begin
			end
		endcase
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cnt_q         <= '0;
			ptr_q         <= '0;
			k_q           <= '0;
			removed_q     <= '0;
			found_q       <= 1'b0;
			drop_succ_q   <= 1'b0;
			func_q        <= FUNC_INSERT;
			key_q         <= '0;
			idx_q         <= '0;
			status_q      <= STATUS_OK;
			rd_q          <= '0;
			rsp_valid_q   <= 1'b0;
			rsp_status_q  <= STATUS_OK;
			rsp_value_q   <= '0;
			rsp_entry_q   <= '0;
			rsp_removed_q <= '0;
		end else begin
			// result beat held until taken, reloaded from the done step
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				// take a request beat and dispatch
				S_IDLE: begin
					if (req.valid) begin
						func_q    <= req.func;
						key_q     <= req.value;
						idx_q     <= XW'(req.index);
						ptr_q     <= '0;
						removed_q <= '0;
						found_q   <= 1'b0;
						status_q  <= STATUS_OK;
						rd_q      <= '0;
						case (req.func)
							FUNC_INSERT: begin
								if (cnt_q == CW'(DEPTH)) begin
									status_q <= STATUS_FULL;
									state_q  <= S_DONE;
								end else begin
									state_q <= S_INS_RD;
								end
							end
							FUNC_REMOVE: begin
								state_q <= S_RM_RD;
							end
							FUNC_READ: begin
								if (XW'(req.index) < XW'(cnt_q)) begin
									state_q <= S_RD_ADDR;
								end else begin
									status_q <= STATUS_RANGE;
									state_q  <= S_DONE;
								end
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				// insert: find first entry not below the key
				S_INS_RD: begin
					if (ptr_q == cnt_q) begin
						k_q     <= cnt_q;
						state_q <= S_INS_SH;
					end else begin
						state_q <= S_INS_CMP;
					end
				end
				S_INS_CMP: begin
					if (cmp.lt) begin
						ptr_q   <= ptr_inc;
						state_q <= S_INS_RD;
					end else begin
						k_q     <= cnt_q;
						state_q <= S_INS_SH;
					end
				end
				// insert: open a gap from the back, then drop the key in
				S_INS_SH: begin
					if (k_q == ptr_q) begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_DONE;
					end else begin
						state_q <= S_INS_WR;
					end
				end
				S_INS_WR: begin
					k_q     <= k_dec;
					state_q <= S_INS_SH;
				end
				// read
				S_RD_ADDR: begin
					state_q <= S_RD_DATA;
				end
				S_RD_DATA: begin
					rd_q    <= ram_rdata;
					state_q <= S_DONE;
				end
				// remove: scan for the key
				S_RM_RD: begin
					if (ptr_q == cnt_q) begin
						status_q <= found_q ? STATUS_OK : STATUS_NOT_FOUND;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_RM_CMP;
					end
				end
				S_RM_CMP: begin
					if (cmp.eq) begin
						found_q <= 1'b1;
						if (ptr_q != '0) begin
							k_q         <= ptr_q - 1'b1;
							drop_succ_q <= 1'b0;
							state_q     <= S_DR_SH;
						end else if (ptr_inc < cnt_q) begin
							k_q         <= ptr_inc;
							drop_succ_q <= 1'b1;
							state_q     <= S_DR_SH;
						end else begin
							ptr_q   <= ptr_inc;
							state_q <= S_RM_RD;
						end
					end else begin
						ptr_q   <= ptr_inc;
						state_q <= S_RM_RD;
					end
				end
				// remove: close the gap at k, moving each following entry one place forward
				S_DR_SH: begin
					if (k_inc >= cnt_q) begin
						cnt_q     <= cnt_q - 1'b1;
						removed_q <= removed_q + 1'b1;
						if (drop_succ_q) begin
							ptr_q   <= ptr_inc;
							state_q <= S_RM_RD;
						end else if (ptr_q < cnt_q - 1'b1) begin
							// match moved one place forward, successor still there
							ptr_q       <= ptr_q - 1'b1;
							k_q         <= ptr_q;
							drop_succ_q <= 1'b1;
						end else begin
							state_q <= S_RM_RD;
						end
					end else begin
						state_q <= S_DR_WR;
					end
				end
				S_DR_WR: begin
					k_q     <= k_inc;
					state_q <= S_DR_SH;
				end
				// hand the result to the output register
				S_DONE: begin
					if (load_rsp) begin
						rsp_status_q  <= status_q;
						rsp_value_q   <= rd_q;
						rsp_entry_q   <= COUNT_W'(cnt_q);
						rsp_removed_q <= (func_q == FUNC_REMOVE) ? COUNT_W'(removed_q) : '0;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/slnr_checker.sv =====
// port-level checks of the sorted list neighbor removal unit, bound to the top level
// depends on slnr_pkg and sorted_list_neighbor_removal_unit_macros.svh
`default_nettype none
`include "sorted_list_neighbor_removal_unit_macros.svh"

module slnr_checker #(
	parameter int unsigned DEPTH = slnr_pkg::DEPTH_DEFAULT
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          req_valid,
	input wire logic                          req_ready,
	input wire logic                          rsp_valid,
	input wire logic [slnr_pkg::STATUS_W-1:0] rsp_status,
	input wire logic [slnr_pkg::VALUE_W-1:0]  rsp_read_value,
	input wire logic [slnr_pkg::COUNT_W-1:0]  rsp_entry_count,
	input wire logic [slnr_pkg::COUNT_W-1:0]  rsp_removed_count
);
	import slnr_pkg::*;

	localparam bit COUNT_FITS = (DEPTH < 32);

	// an accepted beat makes the block busy in the next cycle
	`SLNR_ASSERT_NXT(a_busy_after_accept, clk, arst_n, req_valid && req_ready, !req_ready)

	// the fill count never passes the capacity
	`SLNR_ASSERT_IMP(a_count_bound, clk, arst_n, rsp_valid && COUNT_FITS, rsp_entry_count <= DEPTH)

	// a full report comes only with a full store
	`SLNR_ASSERT_IMP(a_full_count, clk, arst_n,
		rsp_valid && COUNT_FITS && (rsp_status == STATUS_FULL),
		rsp_entry_count == COUNT_W'(DEPTH))

	// a failed operation drops nothing
	`SLNR_ASSERT_IMP(a_err_no_removal, clk, arst_n,
		rsp_valid && (rsp_status != STATUS_OK), rsp_removed_count == '0)

	// a failed operation returns no data
	`SLNR_ASSERT_IMP(a_err_no_data, clk, arst_n,
		rsp_valid && (rsp_status != STATUS_OK), rsp_read_value == '0)

endmodule

bind sorted_list_neighbor_removal_unit slnr_checker #(
	.DEPTH (DEPTH)
) u_slnr_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_status        (rsp.status),
	.rsp_read_value    (rsp.read_value),
	.rsp_entry_count   (rsp.entry_count),
	.rsp_removed_count (rsp.removed_count)
);

`default_nettype wire
